>>> sv/indexed_sequence_store_top_defines.svh
// Assertion macros for the sequence store.
`ifndef INDEXED_SEQUENCE_STORE_TOP_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ISST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ISST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ISST_ASSERT(label, prop, msg)
`define ISST_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> sv/isst_pkg.sv
`default_nettype none

package isst_pkg;

    localparam int ISST_CAPACITY   = 64;
    localparam int ISST_DATA_WIDTH = 32;

    localparam int CMD_W   = 3;
    localparam int INDEX_W = 7;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RESIZE = 3'd5;

    typedef struct packed {
        logic ins;
        logic wr;
        logic rsz;
    } t_cell_op;

endpackage

`default_nettype wire

>>> sv/isst_cell.sv
`default_nettype none

module isst_cell
    import isst_pkg::*;
#(
    parameter int DATA_WIDTH = ISST_DATA_WIDTH,
    parameter int CW         = INDEX_W,
    parameter int POS        = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire t_cell_op              i_op,
    input  wire logic [CW-1:0]         i_idx,
    input  wire logic [CW-1:0]         i_len,
    input  wire logic [DATA_WIDTH-1:0] i_word,
    input  wire logic [DATA_WIDTH-1:0] i_prev,
    output logic      [DATA_WIDTH-1:0] o_data,
    output logic                       o_hit
);

    localparam logic [CW-1:0] P = CW'(POS);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_hit;

    always_comb begin
        n_data = r_data;
        if (i_op.ins) begin
            if (P == i_idx) begin
                n_data = i_word;
            end else if (P > i_idx && P <= i_len) begin
                n_data = i_prev;
            end
        end
        if (i_op.wr && P == i_idx) begin
            n_data = i_word;
        end
        if (i_op.rsz && P >= i_len && P < i_idx) begin
            n_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_hit  <= (r_data == i_word) && (P < i_len);
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

`default_nettype wire

>>> sv/isst_pick.sv
`default_nettype none

module isst_pick
    import isst_pkg::*;
#(
    parameter int CAPACITY = ISST_CAPACITY,
    parameter int IW       = 6
) (
    input  wire logic [CAPACITY-1:0] i_hits,
    output logic                     o_found,
    output logic      [IW-1:0]       o_pos
);

    always_comb begin
        o_found = 1'b0;
        o_pos   = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (i_hits[i]) begin
                o_found = 1'b1;
                o_pos   = IW'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/indexed_sequence_store_top.sv
// The accepting edge updates and compares the cell row and writes the r_b_* command
// registers; the first-match pick and the read select then fill the output register once
// it is free, and the block takes no new item until then.
// A new item is taken while a finished result still waits on the output.
// Reset (synchronous, active low) empties the store and the pipeline; cell words are unset.
`default_nettype none
`include "indexed_sequence_store_top_defines.svh"

module indexed_sequence_store_top
    import isst_pkg::*;
#(
    parameter int CAPACITY   = ISST_CAPACITY,
    parameter int DATA_WIDTH = ISST_DATA_WIDTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic        [CMD_W-1:0]   i_cmd,
    input  wire logic        [INDEX_W-1:0] i_index,
    input  wire logic signed [VALUE_W-1:0] i_value,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_ok,
    output logic signed      [VALUE_W-1:0] o_data_out,
    output logic                           o_found,
    output logic             [POS_W-1:0]   o_position,
    output logic             [COUNT_W-1:0] o_count
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > INDEX_W) ? LW : INDEX_W;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic          r_busy;
    logic          r_b_ok;
    logic [CMD_W-1:0] r_b_cmd;
    logic [IW-1:0] r_b_idx;
    logic          r_ovld;
    logic          r_ok;
    logic [VALUE_W-1:0] r_data_out;
    logic          r_found;
    logic [POS_W-1:0] r_position;
    logic [COUNT_W-1:0] r_count;

    logic [CW-1:0] w_len;
    logic [CW-1:0] w_idx;
    logic [CW-1:0] w_cell_idx;
    logic          w_full;
    logic          w_ok;
    logic          w_accept;
    logic          w_load_out;
    t_cell_op      w_op;
    logic [DATA_WIDTH-1:0] w_word;
    logic [DATA_WIDTH-1:0] w_cell_data [CAPACITY];
    logic [CAPACITY-1:0]   w_hits;
    logic          w_found;
    logic [IW-1:0] w_pos;

    assign w_len    = CW'(r_len);
    assign w_idx    = CW'(i_index);
    assign w_full   = w_len >= CAP_W;
    assign w_word   = DATA_WIDTH'($unsigned(i_value));
    assign w_accept = i_in_valid && o_in_ready;
    assign o_in_ready = !r_busy;
    assign w_load_out = r_busy && (!r_ovld || i_out_ready);

    always_comb begin
        w_ok       = 1'b0;
        w_op       = '0;
        w_cell_idx = w_idx;
        n_len      = r_len;
        unique case (i_cmd)
            CMD_APPEND: begin
                w_ok       = !w_full;
                w_cell_idx = w_len;
                w_op.ins   = w_ok;
                if (w_ok) begin
                    n_len = r_len + LW'(1);
                end
            end
            CMD_INSERT: begin
                w_ok     = !w_full && (w_idx <= w_len);
                w_op.ins = w_ok;
                if (w_ok) begin
                    n_len = r_len + LW'(1);
                end
            end
            CMD_READ: begin
                w_ok = w_idx < w_len;
            end
            CMD_WRITE: begin
                w_ok    = w_idx < w_len;
                w_op.wr = w_ok;
            end
            CMD_FIND: begin
                w_ok = 1'b1;
            end
            CMD_RESIZE: begin
                w_ok     = w_idx <= CAP_W;
                w_op.rsz = w_ok;
                if (w_ok) begin
                    n_len = LW'(w_idx);
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
        if (!w_accept) begin
            w_op = '0;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_rest
            assign w_prev = w_cell_data[g-1];
        end
        isst_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW),
            .POS        (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_accept),
            .i_op   (w_op),
            .i_idx  (w_cell_idx),
            .i_len  (w_len),
            .i_word (w_word),
            .i_prev (w_prev),
            .o_data (w_cell_data[g]),
            .o_hit  (w_hits[g])
        );
    end

    isst_pick #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_pick (
        .i_hits  (w_hits),
        .o_found (w_found),
        .o_pos   (w_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_len  <= n_len;
                r_busy <= 1'b1;
            end else if (w_load_out) begin
                r_busy <= 1'b0;
            end
            if (w_load_out) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_ok  <= w_ok;
            r_b_cmd <= i_cmd;
            r_b_idx <= IW'(i_index);
        end
        if (w_load_out) begin
            r_ok       <= r_b_ok;
            r_data_out <= '0;
            r_found    <= 1'b0;
            r_position <= '0;
            r_count    <= COUNT_W'(r_len);
            if (r_b_ok && r_b_cmd == CMD_READ) begin
                r_data_out <= VALUE_W'($unsigned(w_cell_data[r_b_idx]));
            end
            if (r_b_cmd == CMD_FIND) begin
                r_found    <= w_found;
                r_position <= POS_W'(w_pos);
            end
        end
    end

    assign o_out_valid = r_ovld;
    assign o_ok        = r_ok;
    assign o_data_out  = r_data_out;
    assign o_found     = r_found;
    assign o_position  = r_position;
    assign o_count     = r_count;

    `ISST_ASSERT(a_len_bound, (CW'(r_len) <= CAP_W), "length above capacity")
    `ISST_ASSERT_NEXT(a_accept_busy, w_accept, r_busy, "accepted item not in flight")
    `ISST_ASSERT(a_found_ok, (r_ovld && r_found) |-> r_ok, "found without ok")
    `ISST_ASSERT(a_data_ok, (r_ovld && r_data_out != '0) |-> r_ok, "read data without ok")

endmodule

`default_nettype wire

>>> verif/isst_result_checker.sv
`timescale 1ns / 1ps

module isst_result_checker
    import isst_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [INDEX_W-1:0] i_index,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic               i_ok,
    input  wire logic [VALUE_W-1:0] i_data_out,
    input  wire logic               i_found,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic [COUNT_W-1:0] i_count,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked
);

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] data_out;
        logic               found;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } t_store_result;

    logic [VALUE_W-1:0] stored_words [ISST_CAPACITY];
    int                 stored_len    = 0;
    t_store_result      expected_results [$];
    int                 fail_tally    = 0;
    int                 checked_tally = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic t_store_result apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [INDEX_W-1:0] idx,
                                                    input logic [VALUE_W-1:0] word);
        t_store_result r;
        int            n;
        r = '0;
        case (cmd)
            CMD_APPEND: begin
                if (stored_len < ISST_CAPACITY) begin
                    stored_words[stored_len] = word;
                    stored_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_INSERT: begin
                if (stored_len < ISST_CAPACITY && idx <= stored_len) begin
                    for (n = stored_len; n > idx; n--) begin
                        stored_words[n] = stored_words[n-1];
                    end
                    stored_words[idx] = word;
                    stored_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_READ: begin
                if (idx < stored_len) begin
                    r.data_out = stored_words[idx];
                    r.ok       = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (idx < stored_len) begin
                    stored_words[idx] = word;
                    r.ok              = 1'b1;
                end
            end
            CMD_FIND: begin
                r.ok = 1'b1;
                for (n = 0; n < stored_len && !r.found; n++) begin
                    if (stored_words[n] == word) begin
                        r.found    = 1'b1;
                        r.position = n[POS_W-1:0];
                    end
                end
            end
            CMD_RESIZE: begin
                if (idx <= ISST_CAPACITY) begin
                    for (n = stored_len; n < idx; n++) begin
                        stored_words[n] = '0;
                    end
                    stored_len = int'(idx);
                    r.ok       = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count = stored_len[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_tally++;
        if (fail_tally <= 40) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      checked_tally, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_store_result want;
        if (!i_rst_n) begin
            stored_len = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding: ok %0b count %0d",
                                              i_ok, i_count));
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok", i_ok, want.ok);
                    check_field("data_out", i_data_out, want.data_out);
                    check_field("found", i_found, want.found);
                    check_field("position", i_position, want.position);
                    check_field("count", i_count, want.count);
                    checked_tally++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.insert(expected_results.size(),
                                        apply_command(i_cmd, i_index, i_value));
            end
        end
        o_fail_count <= fail_tally;
        o_pending    <= expected_results.size();
        o_checked    <= checked_tally;
    end

endmodule

>>> verif/indexed_sequence_store_top_tb.sv
`timescale 1ns / 1ps

module indexed_sequence_store_top_tb;
    import isst_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int PHASE_ITEMS = 238;
    localparam int CYCLE_LIMIT = 400000;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic        [CMD_W-1:0]   in_cmd    = CMD_APPEND;
    logic        [INDEX_W-1:0] in_index  = '0;
    logic signed [VALUE_W-1:0] in_value  = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      out_ok;
    logic signed [VALUE_W-1:0] out_data;
    logic                      out_found;
    logic        [POS_W-1:0]   out_position;
    logic        [COUNT_W-1:0] out_count;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int shadow_len     = 0;
    int full_reached   = 0;
    int cycle_count    = 0;
    int cmd_tally [8];

    logic [VALUE_W-1:0] word_pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                          32'h0000_0000, 32'h0000_0001, 32'h5555_5555,
                                          32'hAAAA_AAAA, 32'h1234_5678};

    indexed_sequence_store_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_cmd       (in_cmd),
        .i_index     (in_index),
        .i_value     (in_value),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_ok        (out_ok),
        .o_data_out  (out_data),
        .o_found     (out_found),
        .o_position  (out_position),
        .o_count     (out_count)
    );

    isst_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_cmd        (in_cmd),
        .i_index      (in_index),
        .i_value      (in_value),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_ok         (out_ok),
        .i_data_out   (out_data),
        .i_found      (out_found),
        .i_position   (out_position),
        .i_count      (out_count),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("indexed_sequence_store_top verification failed");
            $finish;
        end
    end

    function automatic logic [VALUE_W-1:0] pick_word();
        logic [VALUE_W-1:0] w;
        if ($urandom_range(1) == 0) begin
            return word_pool[$urandom_range(7)];
        end
        w = $urandom;
        word_pool[$urandom_range(7)] = w;
        return w;
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] word);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_index <= idx;
        in_value <= word;
        do @(posedge clk); while (!in_ready);
        cmd_tally[cmd]++;
        case (cmd)
            CMD_APPEND: begin
                if (shadow_len < ISST_CAPACITY) begin
                    shadow_len++;
                    if (shadow_len == ISST_CAPACITY) full_reached++;
                end
            end
            CMD_INSERT: begin
                if (shadow_len < ISST_CAPACITY && idx <= shadow_len) begin
                    shadow_len++;
                    if (shadow_len == ISST_CAPACITY) full_reached++;
                end
            end
            CMD_RESIZE: begin
                if (idx <= ISST_CAPACITY) begin
                    if (idx == ISST_CAPACITY && shadow_len < ISST_CAPACITY) full_reached++;
                    shadow_len = int'(idx);
                end
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] word;
        int                 phase;
        int                 n;
        int                 pick;
        int                 r;

        foreach (cmd_tally[k]) cmd_tally[k] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_item(CMD_FIND,     7'd0,   32'h0000_0000);
        send_item(CMD_READ,     7'd0,   32'h0000_0000);
        send_item(CMD_WRITE,    7'd0,   32'hFFFF_FFFF);
        send_item(CMD_INSERT,   7'd1,   32'h1111_1111);
        send_item(CMD_INSERT,   7'd0,   32'h8000_0000);
        send_item(CMD_APPEND,   7'd0,   32'h7FFF_FFFF);
        send_item(CMD_APPEND,   7'd127, 32'hFFFF_FFFF);
        send_item(CMD_INSERT,   7'd1,   32'h0000_0001);
        send_item(CMD_READ,     7'd3,   32'h0000_0000);
        send_item(CMD_READ,     7'd4,   32'h0000_0000);
        send_item(CMD_WRITE,    7'd0,   32'h5555_5555);
        send_item(CMD_FIND,     7'd0,   32'hFFFF_FFFF);
        send_item(CMD_FIND,     7'd0,   32'h1234_5678);
        send_item(CMD_RESIZE,   7'd4,   32'h0000_0000);
        send_item(CMD_RESIZE,   7'd64,  32'h0000_0000);
        send_item(CMD_APPEND,   7'd0,   32'h0000_0001);
        send_item(CMD_INSERT,   7'd0,   32'h0000_0002);
        send_item(CMD_READ,     7'd63,  32'h0000_0000);
        send_item(CMD_FIND,     7'd0,   32'h0000_0000);
        send_item(CMD_WRITE,    7'd63,  32'hAAAA_AAAA);
        send_item(CMD_RESIZE,   7'd65,  32'h0000_0000);
        send_item(CMD_RESIZE,   7'd127, 32'hFFFF_FFFF);
        send_item(CMD_SPARE_LO, 7'd127, 32'hFFFF_FFFF);
        send_item(CMD_SPARE_HI, 7'd5,   32'h0000_0000);
        send_item(CMD_RESIZE,   7'd0,   32'h0000_0000);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            n = 0;
            while (n < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                word = pick_word();
                idx  = INDEX_W'($urandom_range(127));
                if (pick < 20) begin
                    cmd = CMD_APPEND;
                end else if (pick < 40) begin
                    cmd = CMD_INSERT;
                    if ($urandom_range(9) != 0) idx = INDEX_W'($urandom_range(shadow_len));
                end else if (pick < 58 || pick < 72) begin
                    cmd = (pick < 58) ? CMD_READ : CMD_WRITE;
                    if (shadow_len > 0 && $urandom_range(7) != 0) begin
                        idx = INDEX_W'($urandom_range(shadow_len - 1));
                    end
                end else if (pick < 88) begin
                    cmd = CMD_FIND;
                    r   = $urandom_range(9);
                    if (r < 6) word = word_pool[$urandom_range(7)];
                    else if (r == 6) word = '0;
                    else word = $urandom;
                end else if (pick < 97) begin
                    cmd = CMD_RESIZE;
                    r   = $urandom_range(9);
                    if (r < 2) idx = INDEX_W'($urandom_range(ISST_CAPACITY));
                    else if (r == 2) idx = INDEX_W'(ISST_CAPACITY);
                    else if (r == 3) idx = INDEX_W'($urandom_range(127, ISST_CAPACITY + 1));
                    else if (r == 4) idx = INDEX_W'(shadow_len);
                    else idx = INDEX_W'($urandom_range(shadow_len));
                end else begin
                    cmd = ($urandom_range(1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
                end
                send_item(cmd, idx, word);
                if (cmd <= CMD_RESIZE) n++;
            end
        end

        in_valid       <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);

        $display("Drove append %0d, insert %0d, read %0d, write %0d, find %0d, resize %0d, spare %0d",
                 cmd_tally[CMD_APPEND], cmd_tally[CMD_INSERT], cmd_tally[CMD_READ],
                 cmd_tally[CMD_WRITE], cmd_tally[CMD_FIND], cmd_tally[CMD_RESIZE],
                 cmd_tally[CMD_SPARE_LO] + cmd_tally[CMD_SPARE_HI]);
        $display("Checked %0d results over four pacing phases; store filled to capacity %0d times",
                 checked, full_reached);
        if (fail_count == 0 && pending == 0) begin
            $display("indexed_sequence_store_top verification clean");
        end else begin
            $display("indexed_sequence_store_top verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/isst_pkg.sv
sv/isst_cell.sv
sv/isst_pick.sv
sv/indexed_sequence_store_top.sv
verif/isst_result_checker.sv
verif/indexed_sequence_store_top_tb.sv
